>>> src/bfbp_pkg.sv
// Shared types and constants for the best-fit block pool.
// No dependencies; compiled first.
package bfbp_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_BLOCKS_DEF = 64;
  localparam int unsigned SIZE_BITS_DEF  = 32;

  // Fixed field widths of the request and response channels
  localparam int unsigned REQ_SIZE_W  = 32;
  localparam int unsigned REL_IDX_W   = 6;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned IDX_FIELD_W = 6;
  localparam int unsigned CAP_FIELD_W = 32;
  localparam int unsigned CNT_FIELD_W = 7;
  localparam int unsigned BYTES_W     = 38;
  localparam int unsigned CFG_W       = 32;

  // Reset value of the minimum block size register
  localparam logic [CFG_W-1:0] MIN_BLOCK_RST = CFG_W'(4096);

  // Request command codes
  localparam logic CMD_ALLOC   = 1'b0;
  localparam logic CMD_RELEASE = 1'b1;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_RELEASED = 3'd3,
    ST_BAD_REL  = 3'd4
  } status_e;

  // Controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch a new request
    logic scan_rd;  // read next table entry for the best-fit scan
    logic rel_rd;   // read the entry named by a release
    logic commit;   // update the table and totals, load the response
  } bfbp_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic req_release; // incoming request is a release
    logic pool_empty;  // no blocks yet
    logic scan_last;   // scan address is the last block
    logic out_free;    // response register can take a new result
  } bfbp_stat_t;

endpackage

>>> src/bfbp_if.sv
// Request and response channel interfaces of the block pool.
// Depends on bfbp_pkg for the field widths.
interface bfbp_in_if;
  logic                               valid;
  logic                               ready;
  logic                               cmd;
  logic [bfbp_pkg::REQ_SIZE_W-1:0]    req_size;
  logic [bfbp_pkg::REL_IDX_W-1:0]     release_index;

  modport source (output valid, cmd, req_size, release_index, input ready);
  modport sink   (input valid, cmd, req_size, release_index, output ready);
endinterface

interface bfbp_out_if;
  logic                               valid;
  logic                               ready;
  logic [bfbp_pkg::STATUS_W-1:0]      status;
  logic [bfbp_pkg::IDX_FIELD_W-1:0]   granted_index;
  logic [bfbp_pkg::CAP_FIELD_W-1:0]   granted_capacity;
  logic [bfbp_pkg::CNT_FIELD_W-1:0]   pool_blocks;
  logic [bfbp_pkg::CNT_FIELD_W-1:0]   busy_blocks;
  logic [bfbp_pkg::BYTES_W-1:0]       pool_bytes;
  logic [bfbp_pkg::BYTES_W-1:0]       busy_bytes;

  modport source (output valid, status, granted_index, granted_capacity, pool_blocks,
                  busy_blocks, pool_bytes, busy_bytes, input ready);
  modport sink   (input valid, status, granted_index, granted_capacity, pool_blocks,
                  busy_blocks, pool_bytes, busy_bytes, output ready);
endinterface

>>> src/bfbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bfbp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/bfbp_ctrl.sv
// Sequencing state machine of the block pool: accept, scan or release read, commit.
// Depends on bfbp_pkg for the command and status structs.
module bfbp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  bfbp_pkg::bfbp_stat_t stat_i,
  output bfbp_pkg::bfbp_cmd_t  cmd_o
);
  import bfbp_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DRAIN  = 5'b00100,
    S_REL    = 5'b01000,
    S_COMMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Next state and command decode
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          if (stat_i.req_release) begin
            state_d = S_REL;
          end else if (stat_i.pool_empty) begin
            state_d = S_COMMIT;
          end else begin
            state_d = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (stat_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last read data is compared here
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_REL: begin
        cmd_o.rel_rd = 1'b1;
        state_d      = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

>>> src/bfbp_dp.sv
// Datapath of the block pool: block table, best-fit compare, totals, response register.
// Depends on bfbp_pkg and bfbp_ram.
module bfbp_dp #(
  parameter int unsigned MAX_BLOCKS = bfbp_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = bfbp_pkg::SIZE_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  bfbp_pkg::bfbp_cmd_t                 cmd_i,
  output bfbp_pkg::bfbp_stat_t                stat_o,
  // request payload
  input  logic                                req_cmd_i,
  input  logic [bfbp_pkg::REQ_SIZE_W-1:0]     req_size_i,
  input  logic [bfbp_pkg::REL_IDX_W-1:0]      req_rel_idx_i,
  // configuration
  input  logic                                cfg_we_i,
  input  logic [bfbp_pkg::CFG_W-1:0]          cfg_wdata_i,
  // response
  output logic                                rsp_valid_o,
  input  logic                                rsp_ready_i,
  output logic [bfbp_pkg::STATUS_W-1:0]       rsp_status_o,
  output logic [bfbp_pkg::IDX_FIELD_W-1:0]    rsp_index_o,
  output logic [bfbp_pkg::CAP_FIELD_W-1:0]    rsp_capacity_o,
  output logic [bfbp_pkg::CNT_FIELD_W-1:0]    rsp_pool_blocks_o,
  output logic [bfbp_pkg::CNT_FIELD_W-1:0]    rsp_busy_blocks_o,
  output logic [bfbp_pkg::BYTES_W-1:0]        rsp_pool_bytes_o,
  output logic [bfbp_pkg::BYTES_W-1:0]        rsp_busy_bytes_o
);
  import bfbp_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned SUM_W = SIZE_BITS + $clog2(MAX_BLOCKS + 1);
  localparam int unsigned CMP_W = (CNT_W > REL_IDX_W) ? CNT_W : REL_IDX_W;
  localparam int unsigned ENT_W = SIZE_BITS + 1;

  // Request registers
  logic                  op_q;
  logic [SIZE_BITS-1:0]  size_q;
  logic [REL_IDX_W-1:0]  rel_idx_q;
  logic [CFG_W-1:0]      min_size_q;

  // Scan state
  logic [IDX_W-1:0]      addr_q;
  logic                  cmp_vld_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic                  found_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [SIZE_BITS-1:0]  best_cap_q;
  logic [SIZE_BITS-1:0]  best_diff_q;

  // Pool totals
  logic [CNT_W-1:0]      blk_total_q, blk_total_d;
  logic [CNT_W-1:0]      busy_total_q, busy_total_d;
  logic [SUM_W-1:0]      bytes_total_q, bytes_total_d;
  logic [SUM_W-1:0]      bytes_busy_q, bytes_busy_d;

  // Response register
  logic                  rsp_vld_q;
  status_e               rsp_st_q, rsp_st_d;
  logic [IDX_FIELD_W-1:0] rsp_idx_q, rsp_idx_d;
  logic [CAP_FIELD_W-1:0] rsp_cap_q, rsp_cap_d;

  // Table port signals; an entry is {busy, capacity}
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENT_W-1:0]      ram_wdata;
  logic                  ram_re;
  logic [IDX_W-1:0]      ram_raddr;
  logic [ENT_W-1:0]      ram_rdata;
  logic                  ent_busy;
  logic [SIZE_BITS-1:0]  ent_cap;
  logic [SIZE_BITS-1:0]  ent_diff;
  logic                  ent_better;
  logic [SIZE_BITS-1:0]  new_cap;
  logic [SIZE_BITS-1:0]  min_cap;
  logic                  rel_ok;

  bfbp_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_BLOCKS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_re    = cmd_i.scan_rd | cmd_i.rel_rd;
  assign ram_raddr = cmd_i.scan_rd ? addr_q : IDX_W'(rel_idx_q);
  assign ent_busy  = ram_rdata[ENT_W-1];
  assign ent_cap   = ram_rdata[SIZE_BITS-1:0];

  // Best-fit compare on the entry read last cycle; strict less keeps the earliest on a tie
  assign ent_diff   = ent_cap - size_q;
  assign ent_better = !ent_busy && (ent_cap >= size_q) && (!found_q || (ent_diff < best_diff_q));

  // Status to the controller
  assign stat_o.req_release = (req_cmd_i == CMD_RELEASE);
  assign stat_o.pool_empty  = (blk_total_q == '0);
  assign stat_o.scan_last   = ((CNT_W'(addr_q) + CNT_W'(1)) == blk_total_q);
  assign stat_o.out_free    = !rsp_vld_q || rsp_ready_i;

  // New block size and release check
  assign min_cap = SIZE_BITS'(min_size_q);
  assign new_cap = (size_q < min_cap) ? min_cap : size_q;
  assign rel_ok  = (CMP_W'(rel_idx_q) < CMP_W'(blk_total_q)) && ent_busy;

  // Commit: table write, totals and response fields
  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = best_idx_q;
    ram_wdata     = {1'b1, best_cap_q};
    blk_total_d   = blk_total_q;
    busy_total_d  = busy_total_q;
    bytes_total_d = bytes_total_q;
    bytes_busy_d  = bytes_busy_q;
    rsp_st_d      = ST_FULL;
    rsp_idx_d     = '0;
    rsp_cap_d     = '0;
    if (op_q == CMD_ALLOC) begin
      if (found_q) begin
        ram_we       = cmd_i.commit;
        busy_total_d = busy_total_q + CNT_W'(1);
        bytes_busy_d = bytes_busy_q + SUM_W'(best_cap_q);
        rsp_st_d     = ST_REUSED;
        rsp_idx_d    = IDX_FIELD_W'(best_idx_q);
        rsp_cap_d    = CAP_FIELD_W'(best_cap_q);
      end else if (blk_total_q != CNT_W'(MAX_BLOCKS)) begin
        ram_we        = cmd_i.commit;
        ram_waddr     = IDX_W'(blk_total_q);
        ram_wdata     = {1'b1, new_cap};
        blk_total_d   = blk_total_q + CNT_W'(1);
        busy_total_d  = busy_total_q + CNT_W'(1);
        bytes_total_d = bytes_total_q + SUM_W'(new_cap);
        bytes_busy_d  = bytes_busy_q + SUM_W'(new_cap);
        rsp_st_d      = ST_NEW;
        rsp_idx_d     = IDX_FIELD_W'(blk_total_q);
        rsp_cap_d     = CAP_FIELD_W'(new_cap);
      end
    end else begin
      rsp_idx_d = IDX_FIELD_W'(rel_idx_q);
      if (rel_ok) begin
        ram_we       = cmd_i.commit;
        ram_waddr    = IDX_W'(rel_idx_q);
        ram_wdata    = {1'b0, ent_cap};
        busy_total_d = busy_total_q - CNT_W'(1);
        bytes_busy_d = bytes_busy_q - SUM_W'(ent_cap);
        rsp_st_d     = ST_RELEASED;
        rsp_cap_d    = CAP_FIELD_W'(ent_cap);
      end else begin
        rsp_st_d = ST_BAD_REL;
      end
    end
  end

  // Control registers: scan progress, totals, config, response valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q        <= '0;
      cmp_vld_q     <= 1'b0;
      found_q       <= 1'b0;
      blk_total_q   <= '0;
      busy_total_q  <= '0;
      bytes_total_q <= '0;
      bytes_busy_q  <= '0;
      min_size_q    <= MIN_BLOCK_RST;
      rsp_vld_q     <= 1'b0;
    end else begin
      cmp_vld_q <= cmd_i.scan_rd;
      if (cfg_we_i) begin
        min_size_q <= cfg_wdata_i;
      end
      if (cmd_i.capture) begin
        addr_q  <= '0;
        found_q <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          addr_q <= addr_q + IDX_W'(1);
        end
        if (cmp_vld_q && ent_better) begin
          found_q <= 1'b1;
        end
      end
      if (cmd_i.commit) begin
        blk_total_q   <= blk_total_d;
        busy_total_q  <= busy_total_d;
        bytes_total_q <= bytes_total_d;
        bytes_busy_q  <= bytes_busy_d;
      end
      if (cmd_i.commit) begin
        rsp_vld_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q      <= req_cmd_i;
      size_q    <= SIZE_BITS'(req_size_i);
      rel_idx_q <= req_rel_idx_i;
    end
    cmp_idx_q <= addr_q;
    if (cmp_vld_q && ent_better) begin
      best_idx_q  <= cmp_idx_q;
      best_cap_q  <= ent_cap;
      best_diff_q <= ent_diff;
    end
    if (cmd_i.commit) begin
      rsp_st_q  <= rsp_st_d;
      rsp_idx_q <= rsp_idx_d;
      rsp_cap_q <= rsp_cap_d;
    end
  end

  // Response outputs; totals are shown as of the last commit
  assign rsp_valid_o       = rsp_vld_q;
  assign rsp_status_o      = rsp_st_q;
  assign rsp_index_o       = rsp_idx_q;
  assign rsp_capacity_o    = rsp_cap_q;
  assign rsp_pool_blocks_o = CNT_FIELD_W'(blk_total_q);
  assign rsp_busy_blocks_o = CNT_FIELD_W'(busy_total_q);
  assign rsp_pool_bytes_o  = BYTES_W'(bytes_total_q);
  assign rsp_busy_bytes_o  = BYTES_W'(bytes_busy_q);

endmodule

>>> src/best_fit_block_pool.sv
// Best-fit block pool allocator, top level. One request at a time.
// Allocate: the block table RAM is scanned one entry per cycle over the N blocks in the
// pool (1..64), the last entry read is compared, and the result commits; an empty pool
// skips the scan. Release: reads the named entry, then commits. Next request after the commit.
// A new request is taken while the previous response still waits; its commit then waits for it.
// Async active-low reset empties the pool and sets the minimum block size to 4096.
module best_fit_block_pool #(
  parameter int unsigned MAX_BLOCKS = bfbp_pkg::MAX_BLOCKS_DEF,
  parameter int unsigned SIZE_BITS  = bfbp_pkg::SIZE_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  bfbp_in_if.sink                     req_i,
  bfbp_out_if.source                  rsp_o,
  input  logic                        cfg_we_i,
  input  logic [bfbp_pkg::CFG_W-1:0]  cfg_wdata_i
);
  import bfbp_pkg::*;

  bfbp_cmd_t  cmd;
  bfbp_stat_t stat;

  bfbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  bfbp_dp #(
    .MAX_BLOCKS (MAX_BLOCKS),
    .SIZE_BITS  (SIZE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .req_cmd_i         (req_i.cmd),
    .req_size_i        (req_i.req_size),
    .req_rel_idx_i     (req_i.release_index),
    .cfg_we_i          (cfg_we_i),
    .cfg_wdata_i       (cfg_wdata_i),
    .rsp_valid_o       (rsp_o.valid),
    .rsp_ready_i       (rsp_o.ready),
    .rsp_status_o      (rsp_o.status),
    .rsp_index_o       (rsp_o.granted_index),
    .rsp_capacity_o    (rsp_o.granted_capacity),
    .rsp_pool_blocks_o (rsp_o.pool_blocks),
    .rsp_busy_blocks_o (rsp_o.busy_blocks),
    .rsp_pool_bytes_o  (rsp_o.pool_bytes),
    .rsp_busy_bytes_o  (rsp_o.busy_bytes)
  );

  // Only one request in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("request accepted while another is in flight");

  // A commit never overwrites a response that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> (!rsp_o.valid || rsp_o.ready))
    else $error("response overwritten before handshake");

  // Every commit shows up as a response in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |=> rsp_o.valid)
    else $error("commit without response");

  // Busy block count never exceeds pool block count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.busy_blocks <= rsp_o.pool_blocks))
    else $error("busy block count above pool block count");

endmodule

>>> sim/bfbp_pool_checker.sv
`timescale 1ns / 100ps
// Response checker for the best-fit block pool: mirrors the block table, predicts each response.
// Depends on bfbp_pkg and the request/response interfaces in bfbp_if.sv.
module bfbp_pool_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  bfbp_in_if                         req_i,
  bfbp_out_if                        rsp_i,
  input  logic                       cfg_we_i,
  input  logic [bfbp_pkg::CFG_W-1:0] cfg_wdata_i,
  output int                         mismatch_o,
  output int                         outstanding_o
);
  import bfbp_pkg::*;

  localparam int unsigned NBLK = MAX_BLOCKS_DEF;

  typedef struct packed {
    status_e                status;
    logic [IDX_FIELD_W-1:0] index;
    logic [CAP_FIELD_W-1:0] capacity;
    logic [CNT_FIELD_W-1:0] blocks;
    logic [CNT_FIELD_W-1:0] busy;
    logic [BYTES_W-1:0]     bytes;
    logic [BYTES_W-1:0]     busy_bytes;
  } pool_result_t;

  // Mirror of the block table and pool totals
  logic [SIZE_BITS_DEF-1:0] cap_tab [NBLK];
  logic                     busy_tab [NBLK];
  int unsigned              blk_count;
  int unsigned              busy_count;
  logic [BYTES_W-1:0]       bytes_sum;
  logic [BYTES_W-1:0]       busy_sum;
  logic [CFG_W-1:0]         min_cap;

  pool_result_t pending_grants [$];
  pool_result_t want;
  pool_result_t got;

  // Apply one request to the mirrored pool and return the response it should produce
  function automatic pool_result_t pool_apply(input logic cmd,
                                              input logic [REQ_SIZE_W-1:0] size,
                                              input logic [REL_IDX_W-1:0] rel_idx);
    pool_result_t r;
    logic found;
    int unsigned best;
    logic [SIZE_BITS_DEF-1:0] best_diff;
    logic [SIZE_BITS_DEF-1:0] new_cap;
    r = '0;
    found = 1'b0;
    best = 0;
    best_diff = '0;
    if (cmd == CMD_ALLOC) begin
      // best fit over free blocks; strict compare keeps the lowest index on a tie
      for (int i = 0; i < blk_count; i++) begin
        if (!busy_tab[i] && cap_tab[i] >= size &&
            (!found || (cap_tab[i] - size) < best_diff)) begin
          found = 1'b1;
          best = i;
          best_diff = cap_tab[i] - size;
          if (best_diff == '0) break;
        end
      end
      if (found) begin
        busy_tab[best] = 1'b1;
        busy_count++;
        busy_sum += cap_tab[best];
        r.status = ST_REUSED;
        r.index = IDX_FIELD_W'(best);
        r.capacity = cap_tab[best];
      end else if (blk_count < NBLK) begin
        new_cap = (size < min_cap) ? min_cap : size;
        cap_tab[blk_count] = new_cap;
        busy_tab[blk_count] = 1'b1;
        r.status = ST_NEW;
        r.index = IDX_FIELD_W'(blk_count);
        r.capacity = new_cap;
        blk_count++;
        busy_count++;
        bytes_sum += new_cap;
        busy_sum += new_cap;
      end else begin
        r.status = ST_FULL;
      end
    end else begin
      r.index = rel_idx;
      if (rel_idx < blk_count && busy_tab[rel_idx]) begin
        busy_tab[rel_idx] = 1'b0;
        busy_count--;
        busy_sum -= cap_tab[rel_idx];
        r.status = ST_RELEASED;
        r.capacity = cap_tab[rel_idx];
      end else begin
        r.status = ST_BAD_REL;
      end
    end
    r.blocks = CNT_FIELD_W'(blk_count);
    r.busy = CNT_FIELD_W'(busy_count);
    r.bytes = bytes_sum;
    r.busy_bytes = busy_sum;
    return r;
  endfunction

  task automatic field_check(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v);
    if (act_v !== exp_v) begin
      mismatch_o++;
      $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
    end
  endtask

  // Track config writes, check responses, queue predictions for new requests
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NBLK; i++) begin
        cap_tab[i] = '0;
        busy_tab[i] = 1'b0;
      end
      blk_count = 0;
      busy_count = 0;
      bytes_sum = '0;
      busy_sum = '0;
      min_cap = MIN_BLOCK_RST;
      pending_grants.delete();
      mismatch_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) min_cap = cfg_wdata_i;

      if (rsp_i.valid && rsp_i.ready) begin
        got.status = status_e'(rsp_i.status);
        got.index = rsp_i.granted_index;
        got.capacity = rsp_i.granted_capacity;
        got.blocks = rsp_i.pool_blocks;
        got.busy = rsp_i.busy_blocks;
        got.bytes = rsp_i.pool_bytes;
        got.busy_bytes = rsp_i.busy_bytes;
        if (pending_grants.size() == 0) begin
          mismatch_o++;
          $display("%0t: response expected none actual status %0d index %0d", $time,
                   got.status, got.index);
        end else begin
          want = pending_grants.pop_front();
          field_check("status", want.status, got.status);
          field_check("granted_index", want.index, got.index);
          field_check("granted_capacity", want.capacity, got.capacity);
          field_check("pool_blocks", want.blocks, got.blocks);
          field_check("busy_blocks", want.busy, got.busy);
          field_check("pool_bytes", want.bytes, got.bytes);
          field_check("busy_bytes", want.busy_bytes, got.busy_bytes);
        end
      end

      if (req_i.valid && req_i.ready)
        pending_grants.push_back(pool_apply(req_i.cmd, req_i.req_size, req_i.release_index));

      outstanding_o = pending_grants.size();
    end
  end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps
// Top of the block pool testbench: clock, reset, request and config stimulus, verdict.
// Depends on bfbp_pkg, bfbp_if.sv, best_fit_block_pool and bfbp_pool_checker.
module testbench;
  import bfbp_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 900_000;
  localparam int unsigned HOLD_CYCLES = 300;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  int               mismatches;
  int               outstanding;
  int unsigned      cycles = 0;
  int unsigned      gap_pct = 8;
  int unsigned      stall_pct = 6;
  logic             hold_rsp = 1'b0;
  logic [CFG_W-1:0] cur_min = MIN_BLOCK_RST;
  int unsigned      seen_blocks = 0;
  int unsigned      seen_busy = 0;

  bfbp_in_if  req_if ();
  bfbp_out_if rsp_if ();

  best_fit_block_pool dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .rsp_o       (rsp_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  bfbp_pool_checker pool_chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .mismatch_o    (mismatches),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Last reported pool occupancy, used to aim releases at existing blocks
  always @(posedge clk_i) begin
    if (rsp_if.valid && rsp_if.ready) begin
      seen_blocks = 32'(rsp_if.pool_blocks);
      seen_busy = 32'(rsp_if.busy_blocks);
    end
  end

  // Response side: random stall bursts, one long hold-off on request
  initial begin : rsp_sink
    int unsigned held;
    logic hold_done;
    hold_done = 1'b0;
    rsp_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_rsp && !hold_done) begin
        hold_done = 1'b1;
        rsp_if.ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
        rsp_if.ready <= 1'b1;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request, with an optional idle burst first; returns at the accepting edge
  task automatic push_request(input logic cmd, input logic [REQ_SIZE_W-1:0] size,
                              input logic [REL_IDX_W-1:0] idx);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    req_if.valid <= 1'b1;
    req_if.cmd <= cmd;
    req_if.req_size <= size;
    req_if.release_index <= idx;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  // Allocate: the unused index field still gets random bits
  task automatic ask_block(input logic [REQ_SIZE_W-1:0] size);
    push_request(CMD_ALLOC, size, REL_IDX_W'($urandom));
  endtask

  task automatic drop_block(input logic [REL_IDX_W-1:0] idx);
    push_request(CMD_RELEASE, $urandom, idx);
  endtask

  // Stop offering and wait until every request has its response; the count is
  // read at the falling edge so the checker has already seen the rising one
  task automatic await_idle();
    req_if.valid <= 1'b0;
    do @(negedge clk_i); while (outstanding != 0);
    @(posedge clk_i);
  endtask

  task automatic set_min_size(input logic [CFG_W-1:0] value);
    await_idle();
    repeat (4) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    cur_min = value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // Size mix: mostly small so blocks get reused, plus boundaries and full-range values
  function automatic logic [REQ_SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 8192);
    if (r < 60) return $urandom_range(0, cur_min);
    if (r < 72) begin
      case ($urandom_range(0, 5))
        0: return '0;
        1: return 1;
        2: return '1;
        3: return cur_min;
        4: return cur_min + 1;
        default: return cur_min - 1;
      endcase
    end
    if (r < 85) return $urandom;
    return REQ_SIZE_W'(1) << $urandom_range(0, 31);
  endfunction

  // Random mix of allocates and releases; release share rises when most blocks are busy
  task automatic random_items(input int count, input int unsigned rel_pct);
    int unsigned pct;
    logic [REL_IDX_W-1:0] idx;
    for (int n = 0; n < count; n++) begin
      pct = rel_pct;
      if (seen_busy > 48) pct = 75;
      else if (seen_busy == 0) pct = 10;
      if ($urandom_range(0, 99) < pct) begin
        if (seen_blocks == 0 || $urandom_range(0, 6) == 0) begin
          idx = REL_IDX_W'($urandom_range(0, 63));
        end else begin
          idx = REL_IDX_W'($urandom_range(0, seen_blocks - 1));
        end
        drop_block(idx);
      end else begin
        ask_block(pick_size());
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    req_if.valid <= 1'b0;
    req_if.cmd <= CMD_ALLOC;
    req_if.req_size <= '0;
    req_if.release_index <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: growth, bad releases, tie, exact fit, best fit, capacity kept on reuse
    ask_block(0);             // new, raised to the minimum
    ask_block(4096);          // new, equal to the minimum
    ask_block('1);            // new, largest size
    ask_block(5000);
    ask_block(4097);
    drop_block(63);           // beyond the pool
    drop_block(5);            // at the pool edge
    drop_block(1);
    drop_block(1);            // already free
    drop_block(0);
    ask_block(10);            // tie between two 4096 blocks, lowest wins
    drop_block(3);
    drop_block(4);
    ask_block(4097);          // exact fit
    ask_block(4500);          // closest larger block
    ask_block(100);
    drop_block(2);
    ask_block(32'h8000_0000); // reuses the largest block, capacity kept
    ask_block('1);
    drop_block(0);
    drop_block(5);
    ask_block('1);            // only the largest free block fits
    ask_block(1);

    // Minimum size zero, bursts on both sides
    set_min_size('0);
    random_items(200, 45);

    // Largest minimum, no idling
    gap_pct = 0;
    stall_pct = 0;
    set_min_size('1);
    random_items(80, 50);

    // Minimum one; the response side holds off long enough to back up requests
    gap_pct = 10;
    stall_pct = 8;
    set_min_size(1);
    hold_rsp = 1'b1;
    random_items(250, 45);

    gap_pct = 3;
    stall_pct = 3;
    set_min_size($urandom_range(0, 65535));
    random_items(250, 40);

    // Fill the pool with largest-size allocates until it reports full
    gap_pct = 12;
    stall_pct = 10;
    set_min_size($urandom);
    for (int n = 0; n < 66; n++) ask_block('1);
    random_items(200, 45);

    // Closing stretch with no idling on either side
    gap_pct = 0;
    stall_pct = 0;
    await_idle();
    random_items(380, 45);

    await_idle();
    repeat (80) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
